### hw/rtl/rotated_region_coordinate_scan_defines.svh
// ---------------------------------------------------------------------------
// rotated region coordinate scan: assertion macros
// shared property forms for the top block, which checks its own control
// ---------------------------------------------------------------------------
`ifndef ROTATED_REGION_COORDINATE_SCAN_DEFINES_SVH
`define ROTATED_REGION_COORDINATE_SCAN_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RRCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RRCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rrcs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrcs_pkg
// types, register indexes and the sequencer program of the coordinate scan
// ---------------------------------------------------------------------------
package rrcs_pkg;

    localparam int MAX_SIDE_DEF   = 8;
    localparam int COORD_BITS_DEF = 16;

    localparam int FIELD_BITS = 16;
    localparam int SIZE_BITS  = 4;
    localparam int CFG_IDX_BITS = 3;
    localparam int PC_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ROTATION = 3'd2,
        CFG_FLIP_H   = 3'd3,
        CFG_FLIP_V   = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rot;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] origin_x;
        logic signed [FIELD_BITS-1:0] origin_y;
        t_rot                         rotation;
        logic                         flip_h;
        logic                         flip_v;
    } t_cfg;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] start_x;
        logic signed [FIELD_BITS-1:0] start_y;
        logic [SIZE_BITS-1:0]         width;
        logic [SIZE_BITS-1:0]         height;
    } t_in_item;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] sample_x;
        logic signed [FIELD_BITS-1:0] sample_y;
        logic signed [FIELD_BITS-1:0] map_x;
        logic signed [FIELD_BITS-1:0] map_y;
        logic                         last;
    } t_out_item;

    // jump conditions of the program
    typedef enum logic [1:0] {
        COND_ALWAYS  = 2'd0,
        COND_NO_WORK = 2'd1,
        COND_MORE    = 2'd2
    } t_cond;

    // one control word: datapath strobes plus a conditional jump
    typedef struct packed {
        logic               accept;
        logic               emit;
        t_cond              cond;
        logic [PC_BITS-1:0] target;
    } t_uop;

    localparam logic [PC_BITS-1:0] STEP_FETCH = 2'd0;
    localparam logic [PC_BITS-1:0] STEP_SCAN  = 2'd1;
    localparam logic [PC_BITS-1:0] STEP_DONE  = 2'd2;
    localparam logic [PC_BITS-1:0] STEP_SPARE = 2'd3;

    localparam t_uop UCODE [2**PC_BITS] = '{
        '{accept: 1'b1, emit: 1'b0, cond: COND_NO_WORK, target: STEP_FETCH},
        '{accept: 1'b0, emit: 1'b1, cond: COND_MORE,    target: STEP_SCAN},
        '{accept: 1'b0, emit: 1'b0, cond: COND_ALWAYS,  target: STEP_FETCH},
        '{accept: 1'b0, emit: 1'b0, cond: COND_ALWAYS,  target: STEP_FETCH}
    };

    // strobes from sequencer to datapath
    typedef struct packed {
        logic accept;
        logic emit;
    } t_ctl;

    // status from datapath to sequencer
    typedef struct packed {
        logic work_taken;
        logic emit_fire;
        logic last_cell;
    } t_sts;

endpackage

### hw/rtl/rotated_region_coordinate_scan.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rotated_region_coordinate_scan
// rotated blit address generator: source and map coordinates of a rectangle
// ---------------------------------------------------------------------------
// A request names a source rectangle (top-left cell, width, height, sides
// above MAX_SIDE saturate). The block walks it row by row, left to right,
// and for every cell transfers the source coordinate and the map coordinate
// given by the programmed origin, quarter-turn rotation and mirror flags,
// with last set on the final cell. A small control rom steps a counter
// through accept, scan and wrap-up; the scan step produces one cell per
// cycle while the output register is free, and an empty request leaves
// the input open. Coordinates wrap at COORD_BITS. Registers must be
// written by the user through the plain write port only while the block
// is idle; the block itself does not enforce this.
// ---------------------------------------------------------------------------
module rotated_region_coordinate_scan #(
    parameter int MAX_SIDE   = rrcs_pkg::MAX_SIDE_DEF,
    parameter int COORD_BITS = rrcs_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  rrcs_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output rrcs_pkg::t_out_item                 o_out_data,
    input  logic                                i_cfg_we,
    input  logic [rrcs_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [rrcs_pkg::FIELD_BITS-1:0]     i_cfg_data
);

    `include "rotated_region_coordinate_scan_defines.svh"

    rrcs_pkg::t_cfg r_cfg;
    rrcs_pkg::t_ctl w_ctl;
    rrcs_pkg::t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (rrcs_pkg::t_cfg_idx'(i_cfg_index))
                rrcs_pkg::CFG_ORIGIN_X: r_cfg.origin_x <= i_cfg_data;
                rrcs_pkg::CFG_ORIGIN_Y: r_cfg.origin_y <= i_cfg_data;
                rrcs_pkg::CFG_ROTATION: r_cfg.rotation <= rrcs_pkg::t_rot'(i_cfg_data[1:0]);
                rrcs_pkg::CFG_FLIP_H:   r_cfg.flip_h   <= i_cfg_data[0];
                rrcs_pkg::CFG_FLIP_V:   r_cfg.flip_v   <= i_cfg_data[0];
                default:                r_cfg          <= r_cfg;
            endcase
        end
    end

    rrcs_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    rrcs_datapath #(
        .MAX_SIDE   (MAX_SIDE),
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_sts       (w_sts),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    assign o_in_ready = w_ctl.accept;

    // an empty rectangle leaves the block ready for the next request
    `RRCS_ASSERT_NEXT(a_empty_stays_ready,
        i_in_valid && o_in_ready && ((i_in_data.width == '0) || (i_in_data.height == '0)),
        o_in_ready, "empty request did not return to accept")

    // a real rectangle closes the input until its cells are out
    `RRCS_ASSERT_NEXT(a_work_blocks_input,
        w_sts.work_taken, !o_in_ready, "input still open after a rectangle was taken")

    // a pending cell that is not the last one means the scan is still running
    `RRCS_ASSERT_NOW(a_mid_scan_not_ready,
        o_out_valid && !o_out_data.last, !o_in_ready, "input open in the middle of a scan")

endmodule

### hw/rtl/rrcs_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrcs_sequencer
// step counter over the control rom with conditional jumps
// ---------------------------------------------------------------------------
module rrcs_sequencer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rrcs_pkg::t_sts i_sts,
    output rrcs_pkg::t_ctl o_ctl
);

    logic [rrcs_pkg::PC_BITS-1:0] r_pc;
    logic [rrcs_pkg::PC_BITS-1:0] n_pc;
    rrcs_pkg::t_uop               w_uop;
    logic                         w_jump;

    assign w_uop = rrcs_pkg::UCODE[r_pc];

    always_comb begin
        unique case (w_uop.cond)
            rrcs_pkg::COND_ALWAYS:  w_jump = 1'b1;
            rrcs_pkg::COND_NO_WORK: w_jump = !i_sts.work_taken;
            rrcs_pkg::COND_MORE:    w_jump = !(i_sts.emit_fire && i_sts.last_cell);
            default:                w_jump = 1'b1;
        endcase
    end

    assign n_pc = w_jump ? w_uop.target : r_pc + rrcs_pkg::PC_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= rrcs_pkg::STEP_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctl.accept = w_uop.accept;
    assign o_ctl.emit   = w_uop.emit;

endmodule

### hw/rtl/rrcs_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrcs_datapath
// scan counters, source coordinates, transform and the output register
// ---------------------------------------------------------------------------
module rrcs_datapath #(
    parameter int MAX_SIDE   = rrcs_pkg::MAX_SIDE_DEF,
    parameter int COORD_BITS = rrcs_pkg::COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrcs_pkg::t_ctl      i_ctl,
    output rrcs_pkg::t_sts      o_sts,
    input  rrcs_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    input  rrcs_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rrcs_pkg::t_out_item o_out_data
);

    localparam int IDX_BITS = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int FB = rrcs_pkg::FIELD_BITS;
    localparam int SB = rrcs_pkg::SIZE_BITS;
    localparam int XB = COORD_BITS + FB;

    logic [COORD_BITS-1:0] r_row_x;
    logic [COORD_BITS-1:0] r_cur_x;
    logic [COORD_BITS-1:0] r_cur_y;
    logic [IDX_BITS-1:0]   r_col;
    logic [IDX_BITS-1:0]   r_row;
    logic [IDX_BITS-1:0]   r_col_end;
    logic [IDX_BITS-1:0]   r_row_end;
    logic                  r_out_valid;
    rrcs_pkg::t_out_item   r_out;

    logic [SB-1:0]         w_w_sat;
    logic [SB-1:0]         w_h_sat;
    logic [SB-1:0]         w_w_m1;
    logic [SB-1:0]         w_h_m1;
    logic                  w_in_fire;
    logic                  w_slot_free;
    logic                  w_emit_fire;
    logic                  w_row_end;
    logic                  w_last;
    logic [XB-1:0]         w_sx_ext;
    logic [XB-1:0]         w_sy_ext;
    logic [XB-1:0]         w_ox_ext;
    logic [XB-1:0]         w_oy_ext;
    logic [COORD_BITS-1:0] w_org_x;
    logic [COORD_BITS-1:0] w_org_y;
    logic [COORD_BITS-1:0] w_fx;
    logic [COORD_BITS-1:0] w_fy;
    logic [COORD_BITS-1:0] w_map_x;
    logic [COORD_BITS-1:0] w_map_y;
    logic [XB-1:0]         w_smp_x_wide;
    logic [XB-1:0]         w_smp_y_wide;
    logic [XB-1:0]         w_map_x_wide;
    logic [XB-1:0]         w_map_y_wide;

    // oversized sides saturate
    assign w_w_sat = (i_in_data.width  > SB'(MAX_SIDE)) ? SB'(MAX_SIDE) : i_in_data.width;
    assign w_h_sat = (i_in_data.height > SB'(MAX_SIDE)) ? SB'(MAX_SIDE) : i_in_data.height;
    assign w_w_m1  = w_w_sat - SB'(1);
    assign w_h_m1  = w_h_sat - SB'(1);

    assign w_in_fire   = i_in_valid && i_ctl.accept;
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_emit_fire = i_ctl.emit && w_slot_free;
    assign w_row_end   = (r_col == r_col_end);
    assign w_last      = w_row_end && (r_row == r_row_end);

    assign o_sts.work_taken = w_in_fire && (w_w_sat != '0) && (w_h_sat != '0);
    assign o_sts.emit_fire  = w_emit_fire;
    assign o_sts.last_cell  = w_last;

    // 16-bit fields into the coordinate width, sign extended or cut
    assign w_sx_ext = {{COORD_BITS{i_in_data.start_x[FB-1]}}, i_in_data.start_x};
    assign w_sy_ext = {{COORD_BITS{i_in_data.start_y[FB-1]}}, i_in_data.start_y};
    assign w_ox_ext = {{COORD_BITS{i_cfg.origin_x[FB-1]}}, i_cfg.origin_x};
    assign w_oy_ext = {{COORD_BITS{i_cfg.origin_y[FB-1]}}, i_cfg.origin_y};
    assign w_org_x  = w_ox_ext[COORD_BITS-1:0];
    assign w_org_y  = w_oy_ext[COORD_BITS-1:0];

    // mirror, then rotate about the origin
    assign w_fx = i_cfg.flip_h ? (COORD_BITS'(0) - r_cur_x) : r_cur_x;
    assign w_fy = i_cfg.flip_v ? (COORD_BITS'(0) - r_cur_y) : r_cur_y;

    always_comb begin
        unique case (i_cfg.rotation)
            rrcs_pkg::ROT_0: begin
                w_map_x = w_org_x + w_fx;
                w_map_y = w_org_y + w_fy;
            end
            rrcs_pkg::ROT_90: begin
                w_map_x = w_org_x - w_fy;
                w_map_y = w_org_y + w_fx;
            end
            rrcs_pkg::ROT_180: begin
                w_map_x = w_org_x - w_fx;
                w_map_y = w_org_y - w_fy;
            end
            default: begin
                w_map_x = w_org_x + w_fy;
                w_map_y = w_org_y - w_fx;
            end
        endcase
    end

    // coordinate width back to the 16-bit fields, zero filled when narrower
    assign w_smp_x_wide = {{FB{1'b0}}, r_cur_x};
    assign w_smp_y_wide = {{FB{1'b0}}, r_cur_y};
    assign w_map_x_wide = {{FB{1'b0}}, w_map_x};
    assign w_map_y_wide = {{FB{1'b0}}, w_map_y};

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_row_x   <= w_sx_ext[COORD_BITS-1:0];
            r_cur_x   <= w_sx_ext[COORD_BITS-1:0];
            r_cur_y   <= w_sy_ext[COORD_BITS-1:0];
            r_col     <= '0;
            r_row     <= '0;
            r_col_end <= w_w_m1[IDX_BITS-1:0];
            r_row_end <= w_h_m1[IDX_BITS-1:0];
        end else if (w_emit_fire) begin
            if (w_row_end) begin
                r_col   <= '0;
                r_row   <= r_row + IDX_BITS'(1);
                r_cur_x <= r_row_x;
                r_cur_y <= r_cur_y + COORD_BITS'(1);
            end else begin
                r_col   <= r_col + IDX_BITS'(1);
                r_cur_x <= r_cur_x + COORD_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit_fire) begin
            r_out.sample_x <= w_smp_x_wide[FB-1:0];
            r_out.sample_y <= w_smp_y_wide[FB-1:0];
            r_out.map_x    <= w_map_x_wide[FB-1:0];
            r_out.map_y    <= w_map_y_wide[FB-1:0];
            r_out.last     <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
